FILE: src/mcr_pkg.sv
`timescale 1ns / 1ps

package mcr_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;

    localparam int NUM_POINTS = 8;
    localparam int ADDR_W     = 16;
    localparam int CRD_W      = 10;   // center and on-screen coordinate width
    localparam int RAD_W      = 10;
    localparam int COLOR_W    = 8;
    localparam int STEP_A_W   = 11;
    localparam int STEP_B_W   = 12;
    localparam int DEC_W      = 16;
    // Signed width of a mirrored coordinate, center plus or minus an offset.
    localparam int PT_W       = 13;
    // Width of the unreduced linear address for the largest screen.
    localparam int PROD_W     = 21;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        t_addr [NUM_POINTS-1:0] addr;
        logic  [NUM_POINTS-1:0] mask;
    } t_points;

    typedef struct packed {
        t_points            pts;
        logic [COLOR_W-1:0] color;
        logic               done;
    } t_result;

endpackage

FILE: src/mcr_emit.sv
`timescale 1ns / 1ps

module mcr_emit (
    input  logic [mcr_pkg::CRD_W-1:0]           i_cx,
    input  logic [mcr_pkg::CRD_W-1:0]           i_cy,
    input  logic [mcr_pkg::STEP_A_W-1:0]        i_a,
    input  logic signed [mcr_pkg::STEP_B_W-1:0] i_b,
    output mcr_pkg::t_points                    o_pts
);

    logic signed [mcr_pkg::PT_W-1:0] cx_s;
    logic signed [mcr_pkg::PT_W-1:0] cy_s;
    logic signed [mcr_pkg::PT_W-1:0] a_s;
    logic signed [mcr_pkg::PT_W-1:0] b_s;
    logic signed [mcr_pkg::PT_W-1:0] px [mcr_pkg::NUM_POINTS];
    logic signed [mcr_pkg::PT_W-1:0] py [mcr_pkg::NUM_POINTS];

    assign cx_s = $signed({{(mcr_pkg::PT_W-mcr_pkg::CRD_W){1'b0}}, i_cx});
    assign cy_s = $signed({{(mcr_pkg::PT_W-mcr_pkg::CRD_W){1'b0}}, i_cy});
    assign a_s  = $signed({{(mcr_pkg::PT_W-mcr_pkg::STEP_A_W){1'b0}}, i_a});
    assign b_s  = {{(mcr_pkg::PT_W-mcr_pkg::STEP_B_W){i_b[mcr_pkg::STEP_B_W-1]}}, i_b};

    // Eight-way symmetry: the first four swap sign of a and b, the last four swap roles.
    always_comb begin
        px[0] = cx_s + a_s;  py[0] = cy_s + b_s;
        px[1] = cx_s - a_s;  py[1] = cy_s + b_s;
        px[2] = cx_s + a_s;  py[2] = cy_s - b_s;
        px[3] = cx_s - a_s;  py[3] = cy_s - b_s;
        px[4] = cx_s + b_s;  py[4] = cy_s + a_s;
        px[5] = cx_s - b_s;  py[5] = cy_s + a_s;
        px[6] = cx_s + b_s;  py[6] = cy_s - a_s;
        px[7] = cx_s - b_s;  py[7] = cy_s - a_s;
    end

    always_comb begin
        logic                       on_x;
        logic                       on_y;
        logic [mcr_pkg::PROD_W-1:0] lin;
        o_pts = '0;
        for (int k = 0; k < mcr_pkg::NUM_POINTS; k++) begin
            on_x = !px[k][mcr_pkg::PT_W-1] &&
                   (px[k][mcr_pkg::PT_W-2:0] <
                    (mcr_pkg::PT_W-1)'(mcr_pkg::SCREEN_WIDTH));
            on_y = !py[k][mcr_pkg::PT_W-1] &&
                   (py[k][mcr_pkg::PT_W-2:0] <
                    (mcr_pkg::PT_W-1)'(mcr_pkg::SCREEN_HEIGHT));
            lin = mcr_pkg::PROD_W'(py[k][mcr_pkg::CRD_W-1:0]) *
                  mcr_pkg::PROD_W'(mcr_pkg::SCREEN_WIDTH) +
                  mcr_pkg::PROD_W'(px[k][mcr_pkg::CRD_W-1:0]);
            if (on_x && on_y) begin
                o_pts.addr[k] = lin[mcr_pkg::ADDR_W-1:0];
                o_pts.mask[k] = 1'b1;
            end
        end
    end

endmodule

FILE: src/midpoint_circle_rasterizer_top.sv
`timescale 1ns / 1ps
// A result is registered into the output buffer at its input transfer.
// Throughput: one item per cycle while o_in_stall is low; the decision update
// and the eight address sums sit between the circle state and a two-entry
// output buffer. Reset (i_rst_n low, synchronous) clears the circle state to
// zero, leaves the block idle and empties the output buffer.

module midpoint_circle_rasterizer_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_command,
    input  logic [mcr_pkg::CRD_W-1:0]    i_center_x,
    input  logic [mcr_pkg::CRD_W-1:0]    i_center_y,
    input  logic [mcr_pkg::RAD_W-1:0]    i_radius,
    input  logic [mcr_pkg::COLOR_W-1:0]  i_color,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [mcr_pkg::ADDR_W-1:0]   o_addr_0,
    output logic [mcr_pkg::ADDR_W-1:0]   o_addr_1,
    output logic [mcr_pkg::ADDR_W-1:0]   o_addr_2,
    output logic [mcr_pkg::ADDR_W-1:0]   o_addr_3,
    output logic [mcr_pkg::ADDR_W-1:0]   o_addr_4,
    output logic [mcr_pkg::ADDR_W-1:0]   o_addr_5,
    output logic [mcr_pkg::ADDR_W-1:0]   o_addr_6,
    output logic [mcr_pkg::ADDR_W-1:0]   o_addr_7,
    output logic [mcr_pkg::NUM_POINTS-1:0] o_point_valid,
    output logic [mcr_pkg::COLOR_W-1:0]  o_pixel_color,
    output logic                         o_circle_done
);

    logic [mcr_pkg::CRD_W-1:0]           r_ctr_x, n_ctr_x;
    logic [mcr_pkg::CRD_W-1:0]           r_ctr_y, n_ctr_y;
    logic [mcr_pkg::COLOR_W-1:0]         r_color, n_color;
    logic [mcr_pkg::STEP_A_W-1:0]        r_a, n_a;
    logic signed [mcr_pkg::STEP_B_W-1:0] r_b, n_b;
    logic signed [mcr_pkg::DEC_W-1:0]    r_dec, n_dec;
    logic                                r_busy, n_busy;

    mcr_pkg::t_result r_out;
    mcr_pkg::t_result r_skid;
    logic             r_out_valid;
    logic             r_skid_valid;

    mcr_pkg::t_points pts;
    mcr_pkg::t_result res;
    logic             in_xfer;
    logic             out_xfer;
    logic             idle_adv;
    logic             done;

    logic [mcr_pkg::STEP_A_W-1:0]        a_inc;
    logic signed [mcr_pkg::STEP_B_W-1:0] b_dec;
    logic signed [mcr_pkg::DEC_W-1:0]    a_inc_s;
    logic signed [mcr_pkg::DEC_W-1:0]    b_dec_s;

    assign in_xfer    = i_in_valid && !r_skid_valid;
    assign out_xfer   = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skid_valid;

    assign idle_adv = (i_command == mcr_pkg::CMD_ADVANCE) && !r_busy;

    assign a_inc   = r_a + 1'b1;
    assign b_dec   = r_b - mcr_pkg::STEP_B_W'(1);
    assign a_inc_s = $signed({{(mcr_pkg::DEC_W-mcr_pkg::STEP_A_W){1'b0}}, a_inc});
    assign b_dec_s = {{(mcr_pkg::DEC_W-mcr_pkg::STEP_B_W){b_dec[mcr_pkg::STEP_B_W-1]}}, b_dec};

    // Next circle state for the item on the input port.
    always_comb begin
        n_ctr_x = r_ctr_x;
        n_ctr_y = r_ctr_y;
        n_color = r_color;
        n_a     = r_a;
        n_b     = r_b;
        n_dec   = r_dec;
        n_busy  = r_busy;
        done    = 1'b1;
        if (i_command == mcr_pkg::CMD_START) begin
            n_ctr_x = i_center_x;
            n_ctr_y = i_center_y;
            n_color = i_color;
            n_a     = '0;
            n_b     = $signed({{(mcr_pkg::STEP_B_W-mcr_pkg::RAD_W){1'b0}}, i_radius});
            n_dec   = mcr_pkg::DEC_W'(3) -
                      $signed({{(mcr_pkg::DEC_W-mcr_pkg::RAD_W-1){1'b0}}, i_radius, 1'b0});
            n_busy  = 1'b1;
            done    = 1'b0;
        end else if (r_busy) begin
            n_a = a_inc;
            if (r_dec > 0) begin
                n_b   = b_dec;
                n_dec = r_dec + ((a_inc_s - b_dec_s) <<< 2) + mcr_pkg::DEC_W'(10);
            end else begin
                n_dec = r_dec + (a_inc_s <<< 2) + mcr_pkg::DEC_W'(6);
            end
            // The circle ends once b has dropped below a.
            done   = $signed({n_b[mcr_pkg::STEP_B_W-1], n_b}) <
                     $signed({2'b00, n_a});
            n_busy = !done;
        end
    end

    mcr_emit u_emit (
        .i_cx  (n_ctr_x),
        .i_cy  (n_ctr_y),
        .i_a   (n_a),
        .i_b   (n_b),
        .o_pts (pts)
    );

    always_comb begin
        res.pts   = idle_adv ? '0 : pts;
        res.color = n_color;
        res.done  = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr_x <= '0;
            r_ctr_y <= '0;
            r_color <= '0;
            r_a     <= '0;
            r_b     <= '0;
            r_dec   <= '0;
            r_busy  <= 1'b0;
        end else if (in_xfer) begin
            r_ctr_x <= n_ctr_x;
            r_ctr_y <= n_ctr_y;
            r_color <= n_color;
            r_a     <= n_a;
            r_b     <= n_b;
            r_dec   <= n_dec;
            r_busy  <= n_busy;
        end
    end

    // Two-entry output buffer: the skid entry takes a new result while the
    // front entry is held by the downstream stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_xfer) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_xfer;
            end
        end else if (in_xfer) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_xfer) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (in_xfer && !r_out_valid) begin
            r_out <= res;
        end
        if (in_xfer && r_out_valid && !out_xfer) begin
            r_skid <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_addr_0      = r_out.pts.addr[0];
    assign o_addr_1      = r_out.pts.addr[1];
    assign o_addr_2      = r_out.pts.addr[2];
    assign o_addr_3      = r_out.pts.addr[3];
    assign o_addr_4      = r_out.pts.addr[4];
    assign o_addr_5      = r_out.pts.addr[5];
    assign o_addr_6      = r_out.pts.addr[6];
    assign o_addr_7      = r_out.pts.addr[7];
    assign o_point_valid = r_out.pts.mask;
    assign o_pixel_color = r_out.color;
    assign o_circle_done = r_out.done;

endmodule

FILE: tb/circle_step_checker.sv
`timescale 1ns / 1ps

module circle_step_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_command,
    input  logic [mcr_pkg::CRD_W-1:0]      i_center_x,
    input  logic [mcr_pkg::CRD_W-1:0]      i_center_y,
    input  logic [mcr_pkg::RAD_W-1:0]      i_radius,
    input  logic [mcr_pkg::COLOR_W-1:0]    i_color,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [mcr_pkg::ADDR_W-1:0]     i_addr_0,
    input  logic [mcr_pkg::ADDR_W-1:0]     i_addr_1,
    input  logic [mcr_pkg::ADDR_W-1:0]     i_addr_2,
    input  logic [mcr_pkg::ADDR_W-1:0]     i_addr_3,
    input  logic [mcr_pkg::ADDR_W-1:0]     i_addr_4,
    input  logic [mcr_pkg::ADDR_W-1:0]     i_addr_5,
    input  logic [mcr_pkg::ADDR_W-1:0]     i_addr_6,
    input  logic [mcr_pkg::ADDR_W-1:0]     i_addr_7,
    input  logic [mcr_pkg::NUM_POINTS-1:0] i_point_valid,
    input  logic [mcr_pkg::COLOR_W-1:0]    i_pixel_color,
    input  logic                           i_circle_done,
    output int                             o_pending,
    output int                             o_fail_count
);

    // Shadow copy of the circle state.
    logic [mcr_pkg::CRD_W-1:0]   ctr_x;
    logic [mcr_pkg::CRD_W-1:0]   ctr_y;
    logic [mcr_pkg::COLOR_W-1:0] draw_color;
    int                          step_a;
    int                          step_b;
    int                          decision;
    logic                        busy;

    mcr_pkg::t_result expected_steps[$];
    int               mismatch_count;
    int               steps_checked;

    assign o_fail_count = mismatch_count;

    initial begin
        mismatch_count = 0;
        steps_checked  = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] step %0d: %s", $realtime, steps_checked, msg);
        mismatch_count++;
    endtask

    task automatic predict_step(
        input  logic                        cmd,
        input  logic [mcr_pkg::CRD_W-1:0]   cx,
        input  logic [mcr_pkg::CRD_W-1:0]   cy,
        input  logic [mcr_pkg::RAD_W-1:0]   r,
        input  logic [mcr_pkg::COLOR_W-1:0] col,
        output mcr_pkg::t_result            res
    );
        int   xs[mcr_pkg::NUM_POINTS];
        int   ys[mcr_pkg::NUM_POINTS];
        int   px;
        int   py;
        int   full_addr;
        logic has_points;
        logic last;

        res        = '0;
        has_points = 1'b1;
        last       = 1'b0;
        if (cmd == mcr_pkg::CMD_START) begin
            ctr_x      = cx;
            ctr_y      = cy;
            draw_color = col;
            step_a     = 0;
            step_b     = int'(r);
            decision   = 3 - 2 * int'(r);
            busy       = 1'b1;
        end else if (!busy) begin
            // An advance with no circle running reports an empty, finished step.
            has_points = 1'b0;
            last       = 1'b1;
        end else begin
            step_a++;
            if (decision > 0) begin
                step_b--;
                decision = decision + 4 * (step_a - step_b) + 10;
            end else begin
                decision = decision + 4 * step_a + 6;
            end
            last = (step_b < step_a);
            if (last) begin
                busy = 1'b0;
            end
        end

        res.color = draw_color;
        res.done  = last;
        if (has_points) begin
            px = int'(ctr_x);
            py = int'(ctr_y);
            xs = '{px + step_a, px - step_a, px + step_a, px - step_a,
                   px + step_b, px - step_b, px + step_b, px - step_b};
            ys = '{py + step_b, py + step_b, py - step_b, py - step_b,
                   py + step_a, py + step_a, py - step_a, py - step_a};
            for (int k = 0; k < mcr_pkg::NUM_POINTS; k++) begin
                if (xs[k] >= 0 && xs[k] < mcr_pkg::SCREEN_WIDTH &&
                    ys[k] >= 0 && ys[k] < mcr_pkg::SCREEN_HEIGHT)
                begin
                    full_addr          = mcr_pkg::SCREEN_WIDTH * ys[k] + xs[k];
                    res.pts.addr[k]    = full_addr[mcr_pkg::ADDR_W-1:0];
                    res.pts.mask[k]    = 1'b1;
                end
            end
        end
    endtask

    task automatic compare_step(input mcr_pkg::t_result want, input mcr_pkg::t_result got);
        for (int k = 0; k < mcr_pkg::NUM_POINTS; k++) begin
            if (got.pts.addr[k] !== want.pts.addr[k]) begin
                report_mismatch($sformatf("addr_%0d is %0d, expected %0d",
                                          k, got.pts.addr[k], want.pts.addr[k]));
            end
        end
        if (got.pts.mask !== want.pts.mask) begin
            report_mismatch($sformatf("point_valid is %b, expected %b",
                                      got.pts.mask, want.pts.mask));
        end
        if (got.color !== want.color) begin
            report_mismatch($sformatf("pixel_color is %0d, expected %0d",
                                      got.color, want.color));
        end
        if (got.done !== want.done) begin
            report_mismatch($sformatf("circle_done is %b, expected %b",
                                      got.done, want.done));
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        mcr_pkg::t_result got;
        mcr_pkg::t_result want;

        if (!i_rst_n) begin
            ctr_x      = '0;
            ctr_y      = '0;
            draw_color = '0;
            step_a     = 0;
            step_b     = 0;
            decision   = 0;
            busy       = 1'b0;
            expected_steps.delete();
        end else begin
            // The result side is handled first: a result never belongs to the
            // input transfer of the same edge.
            if (i_out_valid && !i_out_stall) begin
                got.pts.addr = {i_addr_7, i_addr_6, i_addr_5, i_addr_4,
                                i_addr_3, i_addr_2, i_addr_1, i_addr_0};
                got.pts.mask = i_point_valid;
                got.color    = i_pixel_color;
                got.done     = i_circle_done;
                if (expected_steps.size() == 0) begin
                    report_mismatch("result transfer with no step outstanding");
                end else begin
                    want = expected_steps.pop_front();
                    compare_step(want, got);
                end
                steps_checked++;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_step(i_command, i_center_x, i_center_y, i_radius, i_color, want);
                expected_steps.push_back(want);
            end
        end
        o_pending <= expected_steps.size();
    end

endmodule

FILE: tb/midpoint_circle_rasterizer_top_tb.sv
`timescale 1ns / 1ps

module midpoint_circle_rasterizer_top_tb;

    localparam int TARGET_ITEMS = 900;
    localparam int STUCK_LIMIT  = 1000;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           command = mcr_pkg::CMD_START;
    logic [mcr_pkg::CRD_W-1:0]      center_x = '0;
    logic [mcr_pkg::CRD_W-1:0]      center_y = '0;
    logic [mcr_pkg::RAD_W-1:0]      radius = '0;
    logic [mcr_pkg::COLOR_W-1:0]    color = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [mcr_pkg::ADDR_W-1:0]     addr_0, addr_1, addr_2, addr_3;
    logic [mcr_pkg::ADDR_W-1:0]     addr_4, addr_5, addr_6, addr_7;
    logic [mcr_pkg::NUM_POINTS-1:0] point_valid;
    logic [mcr_pkg::COLOR_W-1:0]    pixel_color;
    logic                           circle_done;

    int pending;
    int fail_count;
    int items_sent = 0;
    int starts_sent = 0;
    int advances_sent = 0;
    int results_seen = 0;
    int stuck_cycles = 0;
    int burst_left = 40;

    always #10 clk = ~clk;

    midpoint_circle_rasterizer_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_command     (command),
        .i_center_x    (center_x),
        .i_center_y    (center_y),
        .i_radius      (radius),
        .i_color       (color),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_addr_0      (addr_0),
        .o_addr_1      (addr_1),
        .o_addr_2      (addr_2),
        .o_addr_3      (addr_3),
        .o_addr_4      (addr_4),
        .o_addr_5      (addr_5),
        .o_addr_6      (addr_6),
        .o_addr_7      (addr_7),
        .o_point_valid (point_valid),
        .o_pixel_color (pixel_color),
        .o_circle_done (circle_done)
    );

    circle_step_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_command     (command),
        .i_center_x    (center_x),
        .i_center_y    (center_y),
        .i_radius      (radius),
        .i_color       (color),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_addr_0      (addr_0),
        .i_addr_1      (addr_1),
        .i_addr_2      (addr_2),
        .i_addr_3      (addr_3),
        .i_addr_4      (addr_4),
        .i_addr_5      (addr_5),
        .i_addr_6      (addr_6),
        .i_addr_7      (addr_7),
        .i_point_valid (point_valid),
        .i_pixel_color (pixel_color),
        .i_circle_done (circle_done),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // Offers one item and returns at the edge where it transfers. Bursts of
    // back-to-back items alternate with random gaps.
    task automatic send_item(
        input logic                        cmd,
        input logic [mcr_pkg::CRD_W-1:0]   cx,
        input logic [mcr_pkg::CRD_W-1:0]   cy,
        input logic [mcr_pkg::RAD_W-1:0]   r,
        input logic [mcr_pkg::COLOR_W-1:0] col
    );
        int gap;

        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        command  <= cmd;
        center_x <= cx;
        center_y <= cy;
        radius   <= r;
        color    <= col;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        if (cmd == mcr_pkg::CMD_START) starts_sent++;
        else advances_sent++;
    endtask

    task automatic send_advance();
        send_item(mcr_pkg::CMD_ADVANCE, mcr_pkg::CRD_W'($urandom),
                  mcr_pkg::CRD_W'($urandom), mcr_pkg::RAD_W'($urandom),
                  mcr_pkg::COLOR_W'($urandom));
    endtask

    // Holds the input side idle until every outstanding step has come back.
    task automatic drain_steps();
        in_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic trace_circle(input logic [mcr_pkg::RAD_W-1:0] r, input int advances,
                                input logic wide_center);
        logic [mcr_pkg::CRD_W-1:0] cx;
        logic [mcr_pkg::CRD_W-1:0] cy;

        if (wide_center) begin
            cx = mcr_pkg::CRD_W'($urandom);
            cy = mcr_pkg::CRD_W'($urandom);
        end else begin
            cx = mcr_pkg::CRD_W'($urandom_range(0, mcr_pkg::SCREEN_WIDTH + 20));
            cy = mcr_pkg::CRD_W'($urandom_range(0, mcr_pkg::SCREEN_HEIGHT + 20));
        end
        send_item(mcr_pkg::CMD_START, cx, cy, r, mcr_pkg::COLOR_W'($urandom));
        repeat (advances) send_advance();
    endtask

    // The receiver runs its own pattern: open stretches, light and heavy
    // random stalling, and long hold-offs that let the block back up.
    initial begin : result_side
        int mode;
        int span;

        while (!rst_n) @(posedge clk);
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        forever begin
            mode = $urandom_range(0, 9);
            span = (mode == 9) ? $urandom_range(40, 70) : $urandom_range(10, 60);
            repeat (span) begin
                case (mode)
                    0, 1, 2: out_stall <= 1'b0;
                    3, 4, 5, 6: out_stall <= ($urandom_range(0, 3) == 0);
                    7, 8: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= 1'b1;
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) results_seen <= results_seen + 1;
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                stuck_cycles <= 0;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("No transfer for %0d cycles", stuck_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int   kind;
        int   r;
        logic paused_midway;

        paused_midway = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: runs back to back into the receiver's first hold-off.
        send_advance();
        send_item(mcr_pkg::CMD_START, 10'd0, 10'd0, 10'd0, 8'd0);
        send_advance();
        send_advance();
        send_item(mcr_pkg::CMD_START, 10'd1023, 10'd1023, 10'd1023, 8'd255);
        send_advance();
        send_advance();
        send_item(mcr_pkg::CMD_START, 10'd319, 10'd199, 10'd1, 8'hAA);
        send_advance();
        send_advance();
        send_item(mcr_pkg::CMD_START, 10'd160, 10'd100, 10'd100, 8'h55);
        send_advance();
        send_item(mcr_pkg::CMD_START, 10'd5, 10'd3, 10'd7, 8'h0F);
        repeat (7) send_advance();
        send_item(mcr_pkg::CMD_START, 10'd0, 10'd199, 10'd250, 8'h80);
        send_advance();
        send_item(mcr_pkg::CMD_START, 10'd512, 10'd0, 10'd3, 8'h01);
        repeat (4) send_advance();
        drain_steps();

        // Random part: mostly whole circles with random centers and colors,
        // some abandoned large ones, and a little noise.
        while (items_sent < TARGET_ITEMS) begin
            kind = $urandom_range(0, 19);
            if (kind < 15) begin
                r = ($urandom_range(0, 11) == 0) ? $urandom_range(41, 200)
                                                 : $urandom_range(0, 40);
                trace_circle(mcr_pkg::RAD_W'(r), (r * 707) / 1000 + $urandom_range(0, 3),
                             $urandom_range(0, 4) == 0);
            end else if (kind < 18) begin
                trace_circle(mcr_pkg::RAD_W'($urandom), $urandom_range(0, 12),
                             $urandom_range(0, 1) == 1);
            end else begin
                send_item(1'($urandom), mcr_pkg::CRD_W'($urandom),
                          mcr_pkg::CRD_W'($urandom), mcr_pkg::RAD_W'($urandom),
                          mcr_pkg::COLOR_W'($urandom));
            end
            if (!paused_midway && items_sent >= TARGET_ITEMS / 2) begin
                paused_midway = 1'b1;
                drain_steps();
            end
        end

        drain_steps();
        repeat (5) @(posedge clk);
        $display("Sent %0d items: %0d circle starts and %0d advances.",
                 items_sent, starts_sent, advances_sent);
        $display("Checked %0d step results against the predicted points.", results_seen);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
